@@ src/sle_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sle_pkg
// Shared sizes, codes and payload types for the sequential list engine.
// ----------------------------------------------------------------------------
package sle_pkg;

    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 31;
    localparam int POS_W    = 11;
    localparam int ACT_W    = 3;
    localparam int ST_W     = 3;
    localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // request actions
    localparam logic [ACT_W-1:0] ACT_INS_FRONT = 3'd0;
    localparam logic [ACT_W-1:0] ACT_INS_BACK  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_INS_POS   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_REM_FRONT = 3'd3;
    localparam logic [ACT_W-1:0] ACT_REM_BACK  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_REM_POS   = 3'd5;
    localparam logic [ACT_W-1:0] ACT_SEARCH    = 3'd6;

    // result status
    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_BADPOS   = 3'd1;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd2;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;

    // operation kinds run by the sequencer
    localparam logic [1:0] OP_INS  = 2'd0;
    localparam logic [1:0] OP_REM  = 2'd1;
    localparam logic [1:0] OP_SRCH = 2'd2;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [POS_W-1:0] position;
        logic [KEY_W-1:0] key;
    } t_req;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [KEY_W-1:0] result_key;
        logic [POS_W-1:0] result_position;
        logic [POS_W-1:0] element_count;
    } t_res;

    // decoded work plan for one request
    typedef struct packed {
        logic              err;
        logic [ST_W-1:0]   err_status;
        logic [1:0]        op;
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] start_addr;
        logic [CNT_W-1:0]  moves;
    } t_plan;

    // store access from the sequencer
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [KEY_W-1:0]  wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

endpackage
`default_nettype wire

@@ src/sequential_list_engine.sv @@
`default_nettype none
// A rejected request is answered straight from idle. Insert and remove
// shift the entries from the target slot to the end of the list (none for
// a back insert), and search reads the list until the first hit.
// Throughput: one request at a time, set by the single store read port that
// moves one entry per cycle. Results are strobed on o_done and cannot stall.
// Reset clears the control state and the count; the store needs no clearing pass.
// ----------------------------------------------------------------------------
// sequential_list_engine
// Packed ordered list of keys with insert, remove and linear search, run
// by a sequencer over one entry store.
// ----------------------------------------------------------------------------
module sequential_list_engine (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire sle_pkg::t_req i_req,
    output logic               busy,
    output logic               o_done,
    output sle_pkg::t_res      o_res
);

    import sle_pkg::*;

    t_plan            plan;
    t_ram_req         ram_req;
    logic [KEY_W-1:0] ram_rdata;
    logic [CNT_W-1:0] count;

    // request check against the current count
    sle_dec u_dec (
        .i_req   (i_req),
        .i_count (count),
        .o_plan  (plan)
    );

    // sequencer
    sle_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req       (i_req),
        .i_plan      (plan),
        .i_ram_rdata (ram_rdata),
        .o_ram       (ram_req),
        .o_count     (count),
        .o_busy      (busy),
        .o_done      (o_done),
        .o_res       (o_res)
    );

    // entry store
    sle_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

endmodule
`default_nettype wire

@@ src/sle_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sle_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ src/sle_dec.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sle_dec
// Request check and planning: rejects full, empty, bad-position and unknown
// requests; plans the first slot, the scan start and the number of reads.
// ----------------------------------------------------------------------------
module sle_dec (
    input  wire sle_pkg::t_req              i_req,
    input  wire logic [sle_pkg::CNT_W-1:0]  i_count,
    output sle_pkg::t_plan                  o_plan
);

    import sle_pkg::*;

    logic [CMP_W-1:0] cnt_x;
    logic [CMP_W-1:0] pos_x;
    logic [CMP_W-1:0] tgt;
    logic [CMP_W-1:0] lo_x;
    logic             full;
    logic             empty;

    always_comb begin
        cnt_x = CMP_W'(i_count);
        pos_x = CMP_W'(i_req.position);
        full  = (i_count == CNT_W'(CAPACITY));
        empty = (i_count == '0);
        tgt   = CMP_W'(1);

        o_plan            = '0;
        o_plan.err_status = ST_OK;
        o_plan.op         = OP_SRCH;
        o_plan.moves      = i_count;

        case (i_req.action)
            ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_POS: begin
                o_plan.op = OP_INS;
                if (i_req.action == ACT_INS_BACK) begin
                    tgt = cnt_x + CMP_W'(1);
                end else if (i_req.action == ACT_INS_POS) begin
                    tgt = pos_x;
                end
                if (full) begin
                    o_plan.err        = 1'b1;
                    o_plan.err_status = ST_FULL;
                end else if (i_req.action == ACT_INS_POS &&
                             (pos_x == '0 || pos_x > cnt_x + CMP_W'(1))) begin
                    o_plan.err        = 1'b1;
                    o_plan.err_status = ST_BADPOS;
                end
            end
            ACT_REM_FRONT, ACT_REM_BACK, ACT_REM_POS: begin
                o_plan.op = OP_REM;
                if (i_req.action == ACT_REM_BACK) begin
                    tgt = cnt_x;
                end else if (i_req.action == ACT_REM_POS) begin
                    tgt = pos_x;
                end
                if (empty) begin
                    o_plan.err        = 1'b1;
                    o_plan.err_status = ST_EMPTY;
                end else if (i_req.action == ACT_REM_POS &&
                             (pos_x == '0 || pos_x > cnt_x)) begin
                    o_plan.err        = 1'b1;
                    o_plan.err_status = ST_BADPOS;
                end
            end
            ACT_SEARCH: begin
                o_plan.op = OP_SRCH;
            end
            default: begin
                o_plan.err        = 1'b1;
                o_plan.err_status = ST_BADPOS;
            end
        endcase

        // slots moved: from the target slot to the end of the list
        lo_x = tgt - CMP_W'(1);
        if (o_plan.op != OP_SRCH) begin
            o_plan.lo    = ADDR_W'(lo_x);
            o_plan.moves = CNT_W'(cnt_x - lo_x);
        end
        if (o_plan.op == OP_INS) begin
            o_plan.start_addr = ADDR_W'(cnt_x - CMP_W'(1));
        end else if (o_plan.op == OP_REM) begin
            o_plan.start_addr = ADDR_W'(lo_x);
        end
    end

endmodule
`default_nettype wire

@@ src/sle_seq.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sle_seq
// Sequencer: walks the store one read a cycle through a shared address
// stepper and key compare, writes shifted entries back, keeps the count
// and registers the result.
// ----------------------------------------------------------------------------
module sle_seq (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire sle_pkg::t_req               i_req,
    input  wire sle_pkg::t_plan              i_plan,
    input  wire logic [sle_pkg::KEY_W-1:0]   i_ram_rdata,
    output sle_pkg::t_ram_req                o_ram,
    output logic [sle_pkg::CNT_W-1:0]        o_count,
    output logic                             o_busy,
    output logic                             o_done,
    output sle_pkg::t_res                    o_res
);

    import sle_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_FINAL = 2'd2;

    logic [1:0]        r_state,    n_state;
    logic [1:0]        r_op,       n_op;
    logic [KEY_W-1:0]  r_key,      n_key;
    logic [ADDR_W-1:0] r_lo,       n_lo;
    logic [ADDR_W-1:0] r_addr,     n_addr;
    logic [CNT_W-1:0]  r_left,     n_left;
    logic              r_rd_v,     n_rd_v;
    logic [ADDR_W-1:0] r_rd_addr,  n_rd_addr;
    logic              r_rd_first, n_rd_first;
    logic [KEY_W-1:0]  r_rem_key,  n_rem_key;
    logic [CNT_W-1:0]  r_count,    n_count;
    logic              r_done,     n_done;
    t_res              r_res,      n_res;

    logic hit;

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_key      = r_key;
        n_lo       = r_lo;
        n_addr     = r_addr;
        n_left     = r_left;
        n_rd_v     = 1'b0;
        n_rd_addr  = r_rd_addr;
        n_rd_first = 1'b0;
        n_rem_key  = r_rem_key;
        n_count    = r_count;
        n_done     = 1'b0;
        n_res      = r_res;
        o_ram      = '0;
        hit        = 1'b0;

        case (r_state)
            // take a request: errors answer at once, work goes to the scan
            S_IDLE: begin
                if (i_start) begin
                    if (i_plan.err) begin
                        n_done                = 1'b1;
                        n_res.status          = i_plan.err_status;
                        n_res.result_key      = '0;
                        n_res.result_position = '0;
                        n_res.element_count   = POS_W'(r_count);
                    end else begin
                        n_state = S_RUN;
                        n_op    = i_plan.op;
                        n_key   = i_req.key;
                        n_lo    = i_plan.lo;
                        n_addr  = i_plan.start_addr;
                        n_left  = i_plan.moves;
                    end
                end
            end

            // one read a cycle, write back the entry read last cycle
            S_RUN: begin
                hit = (r_op == OP_SRCH) && r_rd_v && (i_ram_rdata == r_key);
                if (r_rd_v && r_op == OP_INS) begin
                    o_ram.we    = 1'b1;
                    o_ram.waddr = r_rd_addr + ADDR_W'(1);
                    o_ram.wdata = i_ram_rdata;
                end else if (r_rd_v && r_op == OP_REM && !r_rd_first) begin
                    o_ram.we    = 1'b1;
                    o_ram.waddr = r_rd_addr - ADDR_W'(1);
                    o_ram.wdata = i_ram_rdata;
                end
                if (r_rd_v && r_rd_first) begin
                    n_rem_key = i_ram_rdata;
                end

                if (hit) begin
                    n_state               = S_IDLE;
                    n_done                = 1'b1;
                    n_res.status          = ST_OK;
                    n_res.result_key      = r_key;
                    n_res.result_position = POS_W'(r_rd_addr) + POS_W'(1);
                    n_res.element_count   = POS_W'(r_count);
                end else if (r_left != '0) begin
                    o_ram.re    = 1'b1;
                    o_ram.raddr = r_addr;
                    n_rd_v      = 1'b1;
                    n_rd_addr   = r_addr;
                    n_rd_first  = (r_op == OP_REM) && (r_addr == r_lo);
                    n_left      = r_left - CNT_W'(1);
                    n_addr      = (r_op == OP_INS) ? r_addr - ADDR_W'(1)
                                                   : r_addr + ADDR_W'(1);
                end else if (!r_rd_v) begin
                    if (r_op == OP_INS) begin
                        n_state = S_FINAL;
                    end else if (r_op == OP_REM) begin
                        n_state               = S_IDLE;
                        n_count               = r_count - CNT_W'(1);
                        n_done                = 1'b1;
                        n_res.status          = ST_OK;
                        n_res.result_key      = r_rem_key;
                        n_res.result_position = POS_W'(r_lo) + POS_W'(1);
                        n_res.element_count   = POS_W'(n_count);
                    end else begin
                        n_state               = S_IDLE;
                        n_done                = 1'b1;
                        n_res.status          = ST_NOTFOUND;
                        n_res.result_key      = '0;
                        n_res.result_position = '0;
                        n_res.element_count   = POS_W'(r_count);
                    end
                end
            end

            // place the new key in the opened slot
            S_FINAL: begin
                o_ram.we              = 1'b1;
                o_ram.waddr           = r_lo;
                o_ram.wdata           = r_key;
                n_state               = S_IDLE;
                n_count               = r_count + CNT_W'(1);
                n_done                = 1'b1;
                n_res.status          = ST_OK;
                n_res.result_key      = r_key;
                n_res.result_position = POS_W'(r_lo) + POS_W'(1);
                n_res.element_count   = POS_W'(n_count);
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
            r_rd_v  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
            r_rd_v  <= n_rd_v;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_key      <= n_key;
        r_lo       <= n_lo;
        r_addr     <= n_addr;
        r_left     <= n_left;
        r_rd_addr  <= n_rd_addr;
        r_rd_first <= n_rd_first;
        r_rem_key  <= n_rem_key;
        r_res      <= n_res;
    end

    assign o_count = r_count;
    assign o_busy  = (r_state != S_IDLE);
    assign o_done  = r_done;
    assign o_res   = r_res;

endmodule
`default_nettype wire

@@ dv/sle_list_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sle_list_checker
// Watches the request and result channels of the list engine. It keeps its
// own copy of the list and predicts each result when a request transfer is
// seen. Every result strobe is compared field by field with the oldest
// prediction.
// ----------------------------------------------------------------------------
module sle_list_checker (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire logic          busy,
    input  wire sle_pkg::t_req i_req,
    input  wire logic          o_done,
    input  wire sle_pkg::t_res o_res,
    output int                 fail_count,
    output int                 pending
);

    import sle_pkg::*;

    // shadow of the list contents and length
    logic [KEY_W-1:0] list_keys [CAPACITY];
    int               list_count = 0;
    t_res             expected_results [$];
    int               fail_total = 0;

    function automatic t_res list_result(logic [ST_W-1:0] st, logic [KEY_W-1:0] k, int slot);
        t_res r;
        r.status          = st;
        r.result_key      = k;
        r.result_position = POS_W'(slot);
        r.element_count   = POS_W'(list_count);
        return r;
    endfunction

    // apply one request to the shadow list and return the result it must give
    function automatic t_res apply_list_op(t_req rq);
        int               slot;
        int               i;
        logic [KEY_W-1:0] taken;
        slot = int'(rq.position);
        case (rq.action)
            ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_POS: begin
                // full is checked before the position
                if (list_count >= CAPACITY)
                    return list_result(ST_FULL, '0, 0);
                if (rq.action == ACT_INS_FRONT)
                    slot = 1;
                else if (rq.action == ACT_INS_BACK)
                    slot = list_count + 1;
                else if (slot < 1 || slot > list_count + 1)
                    return list_result(ST_BADPOS, '0, 0);
                for (i = list_count; i >= slot; i--)
                    list_keys[i] = list_keys[i-1];
                list_keys[slot-1] = rq.key;
                list_count++;
                return list_result(ST_OK, rq.key, slot);
            end
            ACT_REM_FRONT, ACT_REM_BACK, ACT_REM_POS: begin
                // empty is checked before the position
                if (list_count == 0)
                    return list_result(ST_EMPTY, '0, 0);
                if (rq.action == ACT_REM_FRONT)
                    slot = 1;
                else if (rq.action == ACT_REM_BACK)
                    slot = list_count;
                else if (slot < 1 || slot > list_count)
                    return list_result(ST_BADPOS, '0, 0);
                taken = list_keys[slot-1];
                for (i = slot; i < list_count; i++)
                    list_keys[i-1] = list_keys[i];
                list_count--;
                return list_result(ST_OK, taken, slot);
            end
            ACT_SEARCH: begin
                // lowest matching slot wins
                for (i = 0; i < list_count; i++)
                    if (list_keys[i] == rq.key)
                        return list_result(ST_OK, rq.key, i + 1);
                return list_result(ST_NOTFOUND, '0, 0);
            end
            default: begin
                return list_result(ST_BADPOS, '0, 0);
            end
        endcase
    endfunction

    function automatic bit field_differs(string name, logic [31:0] want, logic [31:0] got);
        if (want === got)
            return 1'b0;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        return 1'b1;
    endfunction

    // compare result transfers, then record new request transfers
    always @(posedge i_clk) begin : watch
        t_res want;
        bit   bad;
        if (!i_rst_n) begin
            list_count = 0;
            expected_results.delete();
        end else begin
            if (o_done) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result with nothing expected, actual %0h", $time, o_res);
                    fail_total++;
                end else begin
                    want = expected_results.pop_front();
                    bad  = field_differs("status", want.status, o_res.status);
                    bad |= field_differs("result_key", want.result_key, o_res.result_key);
                    bad |= field_differs("result_position", want.result_position,
                                         o_res.result_position);
                    bad |= field_differs("element_count", want.element_count,
                                         o_res.element_count);
                    if (bad)
                        fail_total++;
                end
            end
            if (start && !busy)
                expected_results.push_back(apply_list_op(i_req));
        end
        fail_count <= fail_total;
        pending    <= expected_results.size();
    end

endmodule
`default_nettype wire

@@ dv/tb.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Stimulus for the sequential list engine. A short directed pass covers
// empty, error, extreme and duplicate cases, then random requests run on a
// short list under several sender idle rates.
// Checking is done by the checker module; this top gives the verdict.
// ----------------------------------------------------------------------------
module tb;
    import sle_pkg::*;

    localparam logic [ACT_W-1:0] ACT_UNUSED = 3'd7;
    localparam logic [KEY_W-1:0] KEY_MAX    = '1;
    localparam int RANDOM_ITEMS   = 560;
    localparam int SHORT_LIST     = 48;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = CAPACITY + 8;
    localparam int POS_SPAN       = (1 << POS_W) - 1;

    logic             i_clk   = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start   = 1'b0;
    t_req             i_req   = '0;
    logic             busy;
    logic             o_done;
    t_res             o_res;
    int               fail_count;
    int               pending;
    int               idle_pct     = 0;
    int               list_len     = 0;
    int               stall_cycles = 0;

    sequential_list_engine DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_done  (o_done),
        .o_res   (o_res)
    );

    sle_list_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_done     (o_done),
        .o_res      (o_res),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // list length as last reported, used only to shape stimulus
    always @(posedge i_clk) begin
        if (o_done)
            list_len <= int'(o_res.element_count);
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic t_req make_req(logic [ACT_W-1:0] act, int slot, logic [KEY_W-1:0] k);
        t_req r;
        r.action   = act;
        r.position = POS_W'(slot);
        r.key      = k;
        return r;
    endfunction

    // small keys give duplicates and search hits
    function automatic logic [KEY_W-1:0] random_key();
        if ($urandom_range(0, 99) < 40)
            return KEY_W'($urandom_range(0, 15));
        return KEY_W'($urandom);
    endfunction

    // random request that keeps the list short
    function automatic t_req random_request();
        int               roll;
        int               ins_pct;
        int               slot;
        logic [ACT_W-1:0] act;
        roll = $urandom_range(0, 99);
        if (roll < 2)
            return make_req(ACT_UNUSED, $urandom_range(0, POS_SPAN), random_key());
        if (roll < 27)
            return make_req(ACT_SEARCH, $urandom_range(0, POS_SPAN), random_key());
        ins_pct = (list_len < 4) ? 80 : (list_len > SHORT_LIST) ? 20 : 55;
        if ($urandom_range(0, 99) < ins_pct) begin
            case ($urandom_range(0, 2))
                0: act = ACT_INS_FRONT;
                1: act = ACT_INS_BACK;
                default: act = ACT_INS_POS;
            endcase
            slot = $urandom_range(1, list_len + 1);
        end else begin
            case ($urandom_range(0, 2))
                0: act = ACT_REM_FRONT;
                1: act = ACT_REM_BACK;
                default: act = ACT_REM_POS;
            endcase
            slot = $urandom_range(1, (list_len > 0) ? list_len : 1);
        end
        // occasional position drawn from the whole span, mostly out of range
        if ($urandom_range(0, 99) < 10)
            slot = $urandom_range(0, POS_SPAN);
        return make_req(act, slot, random_key());
    endfunction

    // one request transfer, after an optional idle gap
    task automatic issue_request(input t_req rq);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_req <= rq;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    initial begin
        int n;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty list, bad positions, extremes, duplicates
        issue_request(make_req(ACT_REM_FRONT, 1, KEY_MAX));
        issue_request(make_req(ACT_REM_BACK, 1, '0));
        issue_request(make_req(ACT_REM_POS, 1, '0));
        issue_request(make_req(ACT_SEARCH, 1, '0));
        issue_request(make_req(ACT_INS_POS, 0, 31'h1));
        issue_request(make_req(ACT_INS_POS, 2, 31'h1));
        issue_request(make_req(ACT_INS_FRONT, 0, KEY_MAX));
        issue_request(make_req(ACT_INS_BACK, POS_SPAN, '0));
        issue_request(make_req(ACT_INS_POS, 2, 31'h2AAA_AAAA));
        issue_request(make_req(ACT_INS_POS, 4, 31'h5555_5555));
        issue_request(make_req(ACT_INS_POS, POS_SPAN, 31'h1));
        issue_request(make_req(ACT_SEARCH, 0, '0));
        issue_request(make_req(ACT_SEARCH, 0, 31'h5555_5555));
        issue_request(make_req(ACT_INS_FRONT, 3, '0));
        issue_request(make_req(ACT_SEARCH, 0, '0));
        issue_request(make_req(ACT_UNUSED, POS_SPAN, KEY_MAX));
        issue_request(make_req(ACT_REM_POS, 0, '0));
        issue_request(make_req(ACT_REM_POS, 6, '0));
        issue_request(make_req(ACT_REM_POS, 5, '0));
        issue_request(make_req(ACT_REM_POS, 2, '0));
        issue_request(make_req(ACT_REM_FRONT, 0, '0));
        issue_request(make_req(ACT_REM_BACK, 0, '0));
        issue_request(make_req(ACT_SEARCH, 0, 31'h1));
        issue_request(make_req(ACT_REM_BACK, 0, '0));
        issue_request(make_req(ACT_REM_FRONT, 0, '0));

        // random requests in four idle phases
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            case ((n * 4) / RANDOM_ITEMS)
                0: idle_pct = 0;
                1: idle_pct = 67;
                2: idle_pct = 0;
                default: idle_pct = 30;
            endcase
            issue_request(random_request());
        end
        start <= 1'b0;

        // wait for the last result, then let the block settle
        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
`default_nettype wire
